// ===== design/dct_mask_requantizer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// dct_mask_requantizer_unit_defines.svh
// Assertion macros shared by the requantizer modules.
// Expects clk and rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef DCT_MASK_REQUANTIZER_UNIT_DEFINES_SVH
`define DCT_MASK_REQUANTIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define DMR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DMR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dmr_pkg.sv =====
// ----------------------------------------------------------------------------
// dmr_pkg
// Widths, constants and controller/datapath command types of the requantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmr_pkg;

    localparam int COEF_BITS  = 16;
    localparam int VALUE_W    = 16;
    localparam int MAG_W      = 17;
    localparam int QUANT_W    = 16;
    localparam int OFF_W      = 8;
    localparam int SCALE_W    = 29;
    localparam int PROD_W     = 46;
    localparam int DC_PROD_W  = 33;
    localparam int DC_T_W     = DC_PROD_W - 3;
    localparam int QM_W       = PROD_W + 1 - 8;
    localparam int NUM_W      = QM_W + 8;
    localparam int QUO_BITS   = 17;
    localparam int REV_W      = 18;
    localparam int ERR_W      = 16;
    localparam int SUM_W      = 40;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCALE_W-1:0]   SCALE_RESET = SCALE_W'(129);
    localparam logic [DC_T_W-1:0]    SCALE_BIAS  = DC_T_W'(129);
    localparam logic [QUANT_W-1:0]   QUANT_RESET = QUANT_W'(1);
    localparam logic [OFF_W-1:0]     OFF_RESET   = OFF_W'(128);
    localparam logic [QUO_BITS-1:0]  RM_MAX      = QUO_BITS'(65536);
    localparam logic [SUM_W-1:0]     SUM_MAX     = '1;
    localparam logic [CNT_W-1:0]     DIV_LAST    = CNT_W'(QUO_BITS - 1);

    localparam logic signed [REV_W-1:0] REV_HI = REV_W'((1 << (COEF_BITS - 1)) - 1);
    localparam logic signed [REV_W-1:0] REV_LO = REV_W'(-(1 << (COEF_BITS - 1)));

    localparam logic [CFG_IDX_W-1:0] CFG_MASK_QUANT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_OFFSET = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_DC,
        OP_SCALE,
        OP_MUL_MAG,
        OP_QM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ERR,
        OP_PUBLISH
    } dmr_op_t;

    typedef struct packed {
        logic    load;
        dmr_op_t op;
    } dmr_cmd_t;

endpackage

// ===== design/dct_mask_requantizer_unit.sv =====
// ----------------------------------------------------------------------------
// dct_mask_requantizer_unit
// Mask-driven requantizer for DCT coefficients with running error total.
// ----------------------------------------------------------------------------
// One item at a time. A mask DC item (kind 0) occupies the unit for its transfer,
// a multiply and the scale update, and produces no result. A coefficient (kind 1)
// goes from transfer to result through: multiply, offset multiply, divider setup,
// the radix-2 restoring divider (one quotient bit per cycle), error, then the
// result and updated total enter the output register. The next item is taken
// while that result waits to be transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_mask_requantizer_unit
    import dmr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      image_end,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] new_coef,
    output logic [ERR_W-1:0]          abs_error,
    output logic [SUM_W-1:0]          error_total,
    output logic                      is_last,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    dmr_cmd_t cmd;
    logic     out_free;

    dmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .out_free (out_free),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    dmr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value       (value),
        .image_end   (image_end),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_stall   (out_stall),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .new_coef    (new_coef),
        .abs_error   (abs_error),
        .error_total (error_total),
        .is_last     (is_last)
    );

endmodule

// ===== design/dmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmr_ctrl
// Sequencer: steps one item through multiply and scale update (mask DC) or multiply, divide and result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dct_mask_requantizer_unit_defines.svh"

module dmr_ctrl
    import dmr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     kind,
    input  logic     out_free,
    output logic     in_stall,
    output dmr_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DC,
        S_SCALE,
        S_MUL_MAG,
        S_QM,
        S_DIV_INIT,
        S_DIV,
        S_ERR,
        S_PUBLISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             stall_reg, stall_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = kind ? S_MUL_MAG : S_MUL_DC;
                end
            end
            S_MUL_DC:
            begin
                cmd.op     = OP_MUL_DC;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_IDLE;
            end
            S_MUL_MAG:
            begin
                cmd.op     = OP_MUL_MAG;
                state_next = S_QM;
            end
            S_QM:
            begin
                cmd.op     = OP_QM;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

    `DMR_ASSERT_IMP(a_stall_matches_state, !stall_reg, state_reg == S_IDLE, "stall low outside idle")
    `DMR_ASSERT_IMP(a_publish_needs_room, cmd.op == OP_PUBLISH, out_free, "publish into full output")
    `DMR_ASSERT_NXT(a_div_exit, state_reg == S_DIV && cnt_reg == DIV_LAST, state_reg == S_ERR, "divider overran")

endmodule

// ===== design/dmr_datapath.sv =====
// ----------------------------------------------------------------------------
// dmr_datapath
// Shared multiplier, radix-2 restoring divider, error and running total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dct_mask_requantizer_unit_defines.svh"

module dmr_datapath
    import dmr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dmr_cmd_t                     cmd,
    input  logic signed [VALUE_W-1:0]    value,
    input  logic                         image_end,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         out_stall,
    output logic                         out_free,
    output logic                         out_valid,
    output logic signed [VALUE_W-1:0]    new_coef,
    output logic [ERR_W-1:0]             abs_error,
    output logic [SUM_W-1:0]             error_total,
    output logic                         is_last
);

    logic [QUANT_W-1:0]         mask_quant_reg;
    logic [OFF_W-1:0]           round_offset_reg;
    logic [SCALE_W-1:0]         scale_reg, scale_next;
    logic [SUM_W-1:0]           error_sum_reg;

    logic signed [VALUE_W-1:0]  sv_reg;
    logic                       neg_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       last_reg;

    logic [PROD_W-1:0]          prod_reg;
    logic [QM_W-1:0]            qm_reg;
    logic [SCALE_W-1:0]         rem_reg;
    logic [QUO_BITS-1:0]        quo_reg;
    logic signed [VALUE_W-1:0]  rev_reg;
    logic [ERR_W-1:0]           err_reg;

    logic                       out_valid_reg;
    logic signed [VALUE_W-1:0]  new_coef_reg;
    logic [ERR_W-1:0]           abs_error_reg;
    logic [SUM_W-1:0]           error_total_reg;
    logic                       is_last_reg;

    logic [MAG_W-1:0]           mul_a;
    logic [SCALE_W-1:0]         mul_b;
    logic [PROD_W-1:0]          prod_full;
    logic [MAG_W-1:0]           mag_in;
    logic [DC_T_W-1:0]          dc_t;
    logic [DC_T_W-1:0]          dc_sum;
    logic [PROD_W:0]            qm_sum;
    logic [NUM_W-1:0]           num;
    logic [SCALE_W:0]           div_shift;
    logic [SCALE_W:0]           div_diff;
    logic [QUO_BITS-1:0]        rm_c;
    logic signed [REV_W-1:0]    rev_raw;
    logic signed [REV_W-1:0]    rev_c;
    logic signed [REV_W-1:0]    diff;
    logic [REV_W-1:0]           diff_abs;
    logic [ERR_W-1:0]           err_c;
    logic [SUM_W:0]             sum_wide;
    logic [SUM_W-1:0]           sum_sat;

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.op)
            OP_MUL_DC:
            begin
                mul_a = mag_reg;
                mul_b = SCALE_W'(mask_quant_reg);
            end
            OP_QM:
            begin
                mul_a = MAG_W'(round_offset_reg);
                mul_b = scale_reg;
            end
            default:
            begin
                mul_a = mag_reg;
                mul_b = scale_reg;
            end
        endcase
    end

    assign prod_full = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign mag_in = value[VALUE_W-1] ? MAG_W'(-$signed({value[VALUE_W-1], value}))
                                     : MAG_W'(value);

    // mask DC scale: trunc(dc * quant / 8) + 129, floor 1
    assign dc_t   = prod_reg[DC_PROD_W-1:3];
    assign dc_sum = dc_t + SCALE_BIAS;
    always_comb
    begin
        if (!neg_reg)
        begin
            scale_next = dc_sum[SCALE_W-1:0];
        end
        else if (dc_t >= SCALE_BIAS)
        begin
            scale_next = SCALE_W'(1);
        end
        else
        begin
            scale_next = SCALE_W'(SCALE_BIAS - dc_t);
        end
    end

    assign qm_sum = {1'b0, prod_reg} + (PROD_W + 1)'(round_offset_reg);
    // prod_reg holds offset * scale here
    assign num    = {qm_reg, 8'b0} + NUM_W'(prod_reg[PROD_W-1:8]);

    assign div_shift = {rem_reg, quo_reg[QUO_BITS-1]};
    assign div_diff  = div_shift - {1'b0, scale_reg};

    // rebuild, saturate, error
    always_comb
    begin
        rm_c    = (quo_reg > RM_MAX) ? RM_MAX : quo_reg;
        rev_raw = neg_reg ? -$signed({1'b0, rm_c}) : $signed({1'b0, rm_c});
        if (rev_raw > REV_HI)
        begin
            rev_c = REV_HI;
        end
        else if (rev_raw < REV_LO)
        begin
            rev_c = REV_LO;
        end
        else
        begin
            rev_c = rev_raw;
        end
        diff     = REV_W'(sv_reg) - rev_c;
        diff_abs = diff[REV_W-1] ? REV_W'(-diff) : REV_W'(diff);
        err_c    = (diff_abs[REV_W-1:ERR_W] != '0) ? '1 : diff_abs[ERR_W-1:0];
    end

    assign sum_wide = {1'b0, error_sum_reg} + (SUM_W + 1)'(err_reg);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_quant_reg   <= QUANT_RESET;
            round_offset_reg <= OFF_RESET;
            scale_reg        <= SCALE_RESET;
            error_sum_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_MASK_QUANT:   mask_quant_reg   <= cfg_data[QUANT_W-1:0];
                    CFG_ROUND_OFFSET: round_offset_reg <= cfg_data[OFF_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.op == OP_SCALE)
            begin
                scale_reg <= scale_next;
            end
            if (cmd.op == OP_PUBLISH)
            begin
                error_sum_reg <= last_reg ? '0 : sum_sat;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sv_reg   <= value;
            neg_reg  <= value[VALUE_W-1];
            mag_reg  <= mag_in;
            last_reg <= image_end;
        end
        unique case (cmd.op)
            OP_MUL_DC, OP_MUL_MAG:
            begin
                prod_reg <= prod_full;
            end
            OP_QM:
            begin
                qm_reg   <= qm_sum[PROD_W:8];
                prod_reg <= prod_full;
            end
            OP_DIV_INIT:
            begin
                rem_reg <= num[QUO_BITS+SCALE_W-1:QUO_BITS];
                quo_reg <= num[QUO_BITS-1:0];
            end
            OP_DIV_STEP:
            begin
                if (!div_diff[SCALE_W])
                begin
                    rem_reg <= div_diff[SCALE_W-1:0];
                end
                else
                begin
                    rem_reg <= div_shift[SCALE_W-1:0];
                end
                quo_reg <= {quo_reg[QUO_BITS-2:0], ~div_diff[SCALE_W]};
            end
            OP_ERR:
            begin
                rev_reg <= rev_c[VALUE_W-1:0];
                err_reg <= err_c;
            end
            OP_PUBLISH:
            begin
                new_coef_reg    <= rev_reg;
                abs_error_reg   <= err_reg;
                error_total_reg <= sum_sat;
                is_last_reg     <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign new_coef    = new_coef_reg;
    assign abs_error   = abs_error_reg;
    assign error_total = error_total_reg;
    assign is_last     = is_last_reg;

    `DMR_ASSERT_NXT(a_publish_sets_valid, cmd.op == OP_PUBLISH, out_valid_reg, "result lost")
    `DMR_ASSERT_NXT(a_last_clears_sum, cmd.op == OP_PUBLISH && last_reg, error_sum_reg == '0, "total not cleared")
    `DMR_ASSERT_NXT(a_scale_nonzero, cmd.op == OP_SCALE, scale_reg != '0, "zero block scale")

endmodule
